[hdl/usbseg_pkg.sv]
// Package for the USB endpoint transfer segmenter.
// Command codes, classified operation codes, queue entry type and constants.
// No dependencies.
package usbseg_pkg;

  localparam int unsigned NUM_EP_DEF  = 8;
  localparam int unsigned MAX_PKT_DEF = 64;

  localparam int unsigned SLOT_W     = 5;   // wide enough for 16 endpoints x 2 dirs
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned Q_PTR_W    = 1;

  localparam logic [6:0] EP0_PKT      = 7'd8;
  localparam logic [2:0] EP_LIMIT     = 3'd7;
  localparam logic [6:0] EP0_CNT_MASK = 7'h0F;
  localparam logic [6:0] CNT_MASK     = 7'h7F;

  typedef enum logic [2:0] {
    CMD_BUS_RESET = 3'd0,
    CMD_OPEN      = 3'd1,
    CMD_START     = 3'd2,
    CMD_OUT_PKT   = 3'd3,
    CMD_IN_DONE   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    TYPE_CONTROL = 2'd0,
    TYPE_ISO     = 2'd1,
    TYPE_BULK    = 2'd2,
    TYPE_INTR    = 2'd3
  } xfer_type_e;

  typedef enum logic [2:0] {
    OP_REJECT    = 3'd0,
    OP_BUS_RESET = 3'd1,
    OP_OPEN      = 3'd2,
    OP_START_OUT = 3'd3,
    OP_START_IN  = 3'd4,
    OP_RX        = 3'd5,
    OP_TX        = 3'd6
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [6:0]        psize;    // packet size for open
    logic [15:0]       tlen;     // total length for start
    logic [6:0]        got;      // received byte count, already masked
  } entry_t;

endpackage

[hdl/usb_endpoint_transfer_segmenter_top.sv]
// USB endpoint transfer segmenter, top level: front classifier, queue, engine.
// Depends on usbseg_pkg, usbseg_front, usbseg_queue, usbseg_back.
// Results: an accepted command passes through the queue and then the engine's result
//   registers before its result strobe; every command gives exactly one result.
// Throughput: one command per cycle; the engine retires one queue entry per cycle
//   with a single read-modify-write of the slot tables. Results cannot be stalled.
// Reset: rst_ni clears all slot tables (length, queued count, packet size, short flag)
//   and the queue at once; no clearing pass, commands are taken right after reset.
module usb_endpoint_transfer_segmenter_top #(
  parameter int unsigned NUM_EP  = usbseg_pkg::NUM_EP_DEF,
  parameter int unsigned MAX_PKT = usbseg_pkg::MAX_PKT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [2:0]  ep_num_i,
  input  logic        ep_dir_i,
  input  logic [9:0]  max_packet_i,
  input  logic [1:0]  xfer_type_i,
  input  logic [15:0] total_len_i,
  input  logic [6:0]  rx_count_i,
  output logic        valid_o,
  output logic        ok_o,
  output logic [15:0] copy_offset_o,
  output logic [6:0]  copy_len_o,
  output logic        arm_o,
  output logic        done_res_o,
  output logic [15:0] done_len_o
);

  usbseg_pkg::entry_t front_entry;
  usbseg_pkg::entry_t head_entry;
  logic q_empty, q_full, q_pop;

  // classify the incoming transaction: range checks and table slot
  usbseg_front #(
    .NUM_EP  (NUM_EP),
    .MAX_PKT (MAX_PKT)
  ) u_front (
    .cmd_i        (cmd_i),
    .ep_num_i     (ep_num_i),
    .ep_dir_i     (ep_dir_i),
    .max_packet_i (max_packet_i),
    .xfer_type_i  (xfer_type_i),
    .total_len_i  (total_len_i),
    .rx_count_i   (rx_count_i),
    .entry_o      (front_entry)
  );

  // busy only when the queue is full; the engine drains an entry every cycle
  assign busy = q_full;

  usbseg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start),
    .wdata_i (front_entry),
    .pop_i   (q_pop),
    .rdata_o (head_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // engine: table update and registered result
  usbseg_back #(
    .NUM_EP (NUM_EP)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (!q_empty),
    .entry_i       (head_entry),
    .pop_o         (q_pop),
    .valid_o       (valid_o),
    .ok_o          (ok_o),
    .copy_offset_o (copy_offset_o),
    .copy_len_o    (copy_len_o),
    .arm_o         (arm_o),
    .done_res_o    (done_res_o),
    .done_len_o    (done_len_o)
  );

endmodule

[hdl/usbseg_front.sv]
// Front end: classifies one command into a queue entry (range checks, slot index).
// Depends on usbseg_pkg.
module usbseg_front #(
  parameter int unsigned NUM_EP  = usbseg_pkg::NUM_EP_DEF,
  parameter int unsigned MAX_PKT = usbseg_pkg::MAX_PKT_DEF
) (
  input  logic [2:0]           cmd_i,
  input  logic [2:0]           ep_num_i,
  input  logic                 ep_dir_i,
  input  logic [9:0]           max_packet_i,
  input  logic [1:0]           xfer_type_i,
  input  logic [15:0]          total_len_i,
  input  logic [6:0]           rx_count_i,
  output usbseg_pkg::entry_t   entry_o
);

  logic ep_ok;
  logic open_ok;
  logic [usbseg_pkg::SLOT_W-1:0] slot_dir;
  logic [usbseg_pkg::SLOT_W-1:0] slot_out;
  logic [usbseg_pkg::SLOT_W-1:0] slot_in;

  assign ep_ok   = ({29'd0, ep_num_i} < 32'(NUM_EP));
  assign open_ok = ep_ok && (ep_num_i <= usbseg_pkg::EP_LIMIT)
                   && ({22'd0, max_packet_i} <= 32'(MAX_PKT))
                   && ((xfer_type_i == usbseg_pkg::TYPE_BULK)
                       || (xfer_type_i == usbseg_pkg::TYPE_INTR));

  assign slot_dir = {1'b0, ep_num_i, ep_dir_i};
  assign slot_out = {1'b0, ep_num_i, 1'b0};
  assign slot_in  = {1'b0, ep_num_i, 1'b1};

  always_comb begin
    entry_o       = '0;
    entry_o.op    = usbseg_pkg::OP_REJECT;
    entry_o.psize = max_packet_i[6:0];
    entry_o.tlen  = total_len_i;
    entry_o.got   = (ep_num_i == 3'd0) ? (rx_count_i & usbseg_pkg::EP0_CNT_MASK)
                                       : (rx_count_i & usbseg_pkg::CNT_MASK);
    entry_o.slot  = slot_dir;
    unique case (cmd_i)
      usbseg_pkg::CMD_BUS_RESET: entry_o.op = usbseg_pkg::OP_BUS_RESET;
      usbseg_pkg::CMD_OPEN: begin
        if (open_ok) entry_o.op = usbseg_pkg::OP_OPEN;
      end
      usbseg_pkg::CMD_START: begin
        if (ep_ok) entry_o.op = ep_dir_i ? usbseg_pkg::OP_START_IN
                                         : usbseg_pkg::OP_START_OUT;
      end
      usbseg_pkg::CMD_OUT_PKT: begin
        entry_o.slot = slot_out;
        if (ep_ok) entry_o.op = usbseg_pkg::OP_RX;
      end
      usbseg_pkg::CMD_IN_DONE: begin
        entry_o.slot = slot_in;
        if (ep_ok) entry_o.op = usbseg_pkg::OP_TX;
      end
      default: entry_o.op = usbseg_pkg::OP_REJECT;
    endcase
  end

endmodule

[hdl/usbseg_queue.sv]
// Two-entry queue between the front end and the transfer engine.
// Depends on usbseg_pkg.
module usbseg_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  usbseg_pkg::entry_t wdata_i,
  input  logic               pop_i,
  output usbseg_pkg::entry_t rdata_o,
  output logic               empty_o,
  output logic               full_o
);

  usbseg_pkg::entry_t mem_q [usbseg_pkg::Q_DEPTH];
  logic [usbseg_pkg::Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [usbseg_pkg::Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [usbseg_pkg::Q_PTR_W:0]   cnt_q, cnt_d;
  logic do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (usbseg_pkg::Q_PTR_W+1)'(usbseg_pkg::Q_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + (usbseg_pkg::Q_PTR_W)'(do_push);
    rd_ptr_d = rd_ptr_q + (usbseg_pkg::Q_PTR_W)'(do_pop);
    cnt_d    = cnt_q + (usbseg_pkg::Q_PTR_W+1)'(do_push)
                     - (usbseg_pkg::Q_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (usbseg_pkg::Q_PTR_W+1)'(usbseg_pkg::Q_DEPTH))
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !do_push)
    else $error("push into full queue");

endmodule

[hdl/usbseg_back.sv]
// Transfer engine: per-slot tables and one read-modify-write per queue entry.
// Registered result outputs. Depends on usbseg_pkg.
module usbseg_back #(
  parameter int unsigned NUM_EP = usbseg_pkg::NUM_EP_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avail_i,
  input  usbseg_pkg::entry_t entry_i,
  output logic               pop_o,
  output logic               valid_o,
  output logic               ok_o,
  output logic [15:0]        copy_offset_o,
  output logic [6:0]         copy_len_o,
  output logic               arm_o,
  output logic               done_res_o,
  output logic [15:0]        done_len_o
);

  localparam int unsigned NSLOT = 2 * NUM_EP;
  localparam int unsigned SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

  logic [15:0] total_q  [NSLOT];
  logic [15:0] queued_q [NSLOT];
  logic [6:0]  psize_q  [NSLOT];
  logic        short_q  [NSLOT];

  logic [SW-1:0] s;
  logic [15:0] cur_total, cur_queued, eff_total, eff_queued, rem, new_q;
  logic [6:0]  mp, size, take;
  logic        eff_short, tx_done, rx_short;

  logic        wr_xfer, wr_psize, wr_bus;
  logic [15:0] wr_total, wr_queued;
  logic        wr_short;

  logic        valid_d, ok_d, arm_d, done_d;
  logic [15:0] off_d, dlen_d;
  logic [6:0]  len_d;

  assign s          = entry_i.slot[SW-1:0];
  assign pop_o      = avail_i;
  assign cur_total  = total_q[s];
  assign cur_queued = queued_q[s];
  assign mp         = psize_q[s];

  always_comb begin
    // start IN resets the slot before the first packet is split off
    eff_total  = (entry_i.op == usbseg_pkg::OP_START_IN) ? entry_i.tlen : cur_total;
    eff_queued = (entry_i.op == usbseg_pkg::OP_START_IN) ? 16'd0 : cur_queued;
    eff_short  = (entry_i.op == usbseg_pkg::OP_START_IN) ? 1'b0 : short_q[s];
    rem        = eff_total - eff_queued;
    size       = ({9'd0, mp} < rem) ? mp : rem[6:0];
    tx_done    = ((eff_total != 16'd0) && (eff_total == eff_queued)) || eff_short;
    if (rem <= {9'd0, mp}) take = ({9'd0, entry_i.got} > rem) ? rem[6:0] : entry_i.got;
    else                   take = (entry_i.got > mp) ? mp : entry_i.got;
    rx_short   = (entry_i.got < mp);
    new_q      = (entry_i.op == usbseg_pkg::OP_RX) ? cur_queued + {9'd0, entry_i.got}
                                                   : eff_queued + {9'd0, size};
  end

  always_comb begin
    valid_d   = avail_i;
    ok_d      = 1'b0;
    arm_d     = 1'b0;
    done_d    = 1'b0;
    off_d     = '0;
    dlen_d    = '0;
    len_d     = '0;
    wr_xfer   = 1'b0;
    wr_psize  = 1'b0;
    wr_bus    = 1'b0;
    wr_total  = eff_total;
    wr_queued = eff_queued;
    wr_short  = eff_short;
    unique case (entry_i.op)
      usbseg_pkg::OP_REJECT: ;
      usbseg_pkg::OP_BUS_RESET: begin
        ok_d   = 1'b1;
        arm_d  = 1'b1;
        wr_bus = 1'b1;
      end
      usbseg_pkg::OP_OPEN: begin
        ok_d     = 1'b1;
        wr_psize = 1'b1;
      end
      usbseg_pkg::OP_START_OUT: begin
        ok_d      = 1'b1;
        arm_d     = 1'b1;
        wr_xfer   = 1'b1;
        wr_total  = entry_i.tlen;
        wr_queued = 16'd0;
        wr_short  = 1'b0;
      end
      usbseg_pkg::OP_START_IN, usbseg_pkg::OP_TX: begin
        ok_d    = 1'b1;
        wr_xfer = 1'b1;
        if (tx_done) begin
          done_d = 1'b1;
          dlen_d = eff_queued;
        end else begin
          off_d     = eff_queued;
          len_d     = size;
          arm_d     = 1'b1;
          wr_queued = new_q;
          wr_short  = (size < mp);
        end
      end
      usbseg_pkg::OP_RX: begin
        ok_d      = 1'b1;
        wr_xfer   = 1'b1;
        off_d     = cur_queued;
        len_d     = take;
        wr_queued = new_q;
        wr_short  = rx_short;
        if ((cur_total == new_q) || rx_short) begin
          done_d = 1'b1;
          dlen_d = new_q;
        end else begin
          arm_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSLOT; i++) begin
        total_q[i]  <= '0;
        queued_q[i] <= '0;
        psize_q[i]  <= '0;
        short_q[i]  <= 1'b0;
      end
    end else if (avail_i) begin
      if (wr_xfer) begin
        total_q[s]  <= wr_total;
        queued_q[s] <= wr_queued;
        short_q[s]  <= wr_short;
      end
      if (wr_psize) psize_q[s] <= entry_i.psize;
      if (wr_bus) begin
        psize_q[0] <= usbseg_pkg::EP0_PKT;
        psize_q[1] <= usbseg_pkg::EP0_PKT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_o          <= ok_d;
    arm_o         <= arm_d;
    done_res_o    <= done_d;
    copy_offset_o <= off_d;
    copy_len_o    <= len_d;
    done_len_o    <= dlen_d;
  end

  a_arm_xor_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(arm_o && done_res_o))
    else $error("arm and done in one result");
  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ok_o) |-> (!arm_o && !done_res_o && copy_len_o == 7'd0))
    else $error("rejected command produced activity");
  a_valid_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_o)
    else $error("popped entry gave no result");

endmodule
